/* src/fdr_pkg.sv */
// fdr_pkg: shared types, constants and one-step arithmetic helpers for the
// fresnel dielectric reflectance pipeline; no dependencies
package fdr_pkg;

  localparam logic [15:0] ONE_Q14     = 16'd16384;
  localparam logic [15:0] ONE_Q15     = 16'd32768;
  localparam logic [15:0] NI_RESET    = 16'd4096;
  localparam logic [15:0] NT_RESET    = 16'd6144;
  localparam logic [29:0] ONE_SQ_Q28  = 30'h1000_0000;

  localparam logic [1:0]  REG_INCIDENT = 2'd0;
  localparam logic [1:0]  REG_TRANSMIT = 2'd1;

  localparam int SQRT_STEPS = 15;
  localparam int ST_STEPS   = 15;
  localparam int RATIO_STEPS = 16;

  // remainder/root pair of the digit-by-digit square root
  typedef struct packed {
    logic [29:0] rem;
    logic [29:0] root;
  } sq_t;

  // remainder/quotient pair of the restoring divider
  typedef struct packed {
    logic [46:0] rem;
    logic [15:0] quo;
  } dv_t;

  // side data that travels with each item
  typedef struct packed {
    logic [15:0] ni;
    logic [15:0] nt;
    logic [14:0] cm;
    logic        tir;
  } carry_t;

  function automatic sq_t sqrt_step(sq_t s, int k);
    logic [29:0] b;
    logic [29:0] t;
    sq_t r;
    b = 30'd1 << (2 * k);
    t = s.root + b;
    if (s.rem >= t) begin
      r.rem  = s.rem - t;
      r.root = (s.root >> 1) + b;
    end else begin
      r.rem  = s.rem;
      r.root = s.root >> 1;
    end
    return r;
  endfunction

  function automatic dv_t div_step(dv_t s, logic [31:0] den, int k);
    logic [46:0] t;
    dv_t r;
    t = {15'd0, den} << k;
    r = s;
    if (s.rem >= t) begin
      r.rem = s.rem - t;
      r.quo = s.quo | (16'd1 << k);
    end
    return r;
  endfunction

endpackage

/* src/fresnel_dielectric_reflectance_unit.sv */
// fresnel_dielectric_reflectance_unit: fully pipelined unpolarized fresnel
// reflectance at a dielectric boundary; depends on fdr_pkg
//
// One cosine (signed Q2.14) is taken in every cycle at which start is high;
// busy never rises. The result (reflectance in Q1.15, total_internal flag)
// shows up on the cycle that done is high, for one cycle only. The pipeline
// holds two 15-step square root pipelines, a 15-step divider for the
// transmitted sine and a pair of 16-step dividers for the amplitude ratios,
// one digit per stage. Index registers are written through cfg_write,
// cfg_index and cfg_data and should only change while no item is in flight.
module fresnel_dielectric_reflectance_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic signed [15:0] cos_incident,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        done,
  output logic [15:0] reflectance,
  output logic        total_internal
);
  import fdr_pkg::*;

  logic [15:0] incident_index;
  logic [15:0] transmit_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      incident_index <= NI_RESET;
      transmit_index <= NT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_INCIDENT: incident_index <= cfg_data;
        REG_TRANSMIT: transmit_index <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // input stage: clamp, pick side, fold sign
  logic        x_v;
  carry_t      x_c;
  logic [15:0] ni_in, nt_in;
  logic        neg_side;
  logic [14:0] cm_in;

  always_comb begin
    ni_in = (incident_index == 16'd0) ? 16'd1 : incident_index;
    nt_in = (transmit_index == 16'd0) ? 16'd1 : transmit_index;
    neg_side = (cos_incident <= 16'sd0);
    if (cos_incident > 16'sd16384 || cos_incident < -16'sd16384) cm_in = 15'd16384;
    else if (neg_side) cm_in = 15'(-cos_incident);
    else cm_in = 15'(cos_incident);
  end

  always_ff @(posedge clk) begin
    if (rst) x_v <= 1'b0;
    else x_v <= start;
    x_c.cm  <= cm_in;
    x_c.ni  <= neg_side ? nt_in : ni_in;
    x_c.nt  <= neg_side ? ni_in : nt_in;
    x_c.tir <= 1'b0;
  end

  // incident sine: sqrt(1 - c^2)
  logic   a_v [SQRT_STEPS+1];
  sq_t    a_s [SQRT_STEPS+1];
  carry_t a_c [SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= SQRT_STEPS; j++) a_v[j] <= 1'b0;
    end else begin
      a_v[0] <= x_v;
      for (int j = 0; j < SQRT_STEPS; j++) a_v[j+1] <= a_v[j];
    end
    a_s[0].rem  <= ONE_SQ_Q28 - 30'(x_c.cm * x_c.cm);
    a_s[0].root <= 30'd0;
    a_c[0]      <= x_c;
    for (int j = 0; j < SQRT_STEPS; j++) begin
      a_s[j+1] <= sqrt_step(a_s[j], SQRT_STEPS - 1 - j);
      a_c[j+1] <= a_c[j];
    end
  end

  // snell: st = ni*si / nt, with the total internal reflection test
  logic [14:0] si;
  logic [30:0] nisi;
  assign si   = a_s[SQRT_STEPS].root[14:0];
  assign nisi = 31'(a_c[SQRT_STEPS].ni * si);

  logic   d_v [ST_STEPS+1];
  dv_t    d_s [ST_STEPS+1];
  carry_t d_c [ST_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= ST_STEPS; j++) d_v[j] <= 1'b0;
    end else begin
      d_v[0] <= a_v[SQRT_STEPS];
      for (int j = 0; j < ST_STEPS; j++) d_v[j+1] <= d_v[j];
    end
    d_s[0].rem <= {16'd0, nisi};
    d_s[0].quo <= 16'd0;
    d_c[0]     <= '{ni: a_c[SQRT_STEPS].ni, nt: a_c[SQRT_STEPS].nt,
                    cm: a_c[SQRT_STEPS].cm,
                    tir: nisi > {1'b0, a_c[SQRT_STEPS].nt, 14'd0}};
    for (int j = 0; j < ST_STEPS; j++) begin
      d_s[j+1] <= div_step(d_s[j], {16'd0, d_c[j].nt}, ST_STEPS - 1 - j);
      d_c[j+1] <= d_c[j];
    end
  end

  // transmitted cosine: sqrt(1 - st^2)
  logic [14:0] st;
  assign st = d_s[ST_STEPS].quo[14:0];

  logic   b_v [SQRT_STEPS+1];
  sq_t    b_s [SQRT_STEPS+1];
  carry_t b_c [SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= SQRT_STEPS; j++) b_v[j] <= 1'b0;
    end else begin
      b_v[0] <= d_v[ST_STEPS];
      for (int j = 0; j < SQRT_STEPS; j++) b_v[j+1] <= b_v[j];
    end
    // wraps only on total internal reflection, where the value is unused
    b_s[0].rem  <= ONE_SQ_Q28 - 30'(st * st);
    b_s[0].root <= 30'd0;
    b_c[0]      <= d_c[ST_STEPS];
    for (int j = 0; j < SQRT_STEPS; j++) begin
      b_s[j+1] <= sqrt_step(b_s[j], SQRT_STEPS - 1 - j);
      b_c[j+1] <= b_c[j];
    end
  end

  // cross products
  logic [14:0] ct;
  assign ct = b_s[SQRT_STEPS].root[14:0];

  logic        m_v;
  logic        m_tir;
  logic [30:0] m_a, m_b, m_c, m_d;

  always_ff @(posedge clk) begin
    if (rst) m_v <= 1'b0;
    else m_v <= b_v[SQRT_STEPS];
    m_tir <= b_c[SQRT_STEPS].tir;
    m_a   <= 31'(b_c[SQRT_STEPS].nt * b_c[SQRT_STEPS].cm);
    m_b   <= 31'(b_c[SQRT_STEPS].ni * ct);
    m_c   <= 31'(b_c[SQRT_STEPS].ni * b_c[SQRT_STEPS].cm);
    m_d   <= 31'(b_c[SQRT_STEPS].nt * ct);
  end

  // amplitude ratios, rounded: (|p-q|*2^15 + (p+q)/2) / (p+q)
  logic [31:0] np, dp, ns, ds;
  always_comb begin
    np = (m_a > m_b) ? 32'(m_a - m_b) : 32'(m_b - m_a);
    dp = 32'(m_a) + 32'(m_b);
    ns = (m_c > m_d) ? 32'(m_c - m_d) : 32'(m_d - m_c);
    ds = 32'(m_c) + 32'(m_d);
  end

  logic        e_v   [RATIO_STEPS+1];
  logic        e_tir [RATIO_STEPS+1];
  dv_t         e_p   [RATIO_STEPS+1];
  dv_t         e_s   [RATIO_STEPS+1];
  logic [31:0] e_dp  [RATIO_STEPS+1];
  logic [31:0] e_ds  [RATIO_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= RATIO_STEPS; j++) e_v[j] <= 1'b0;
    end else begin
      e_v[0] <= m_v;
      for (int j = 0; j < RATIO_STEPS; j++) e_v[j+1] <= e_v[j];
    end
    e_tir[0]   <= m_tir;
    e_p[0].rem <= {np, 15'd0} + 47'(dp >> 1);
    e_p[0].quo <= 16'd0;
    e_s[0].rem <= {ns, 15'd0} + 47'(ds >> 1);
    e_s[0].quo <= 16'd0;
    e_dp[0]    <= dp;
    e_ds[0]    <= ds;
    for (int j = 0; j < RATIO_STEPS; j++) begin
      e_p[j+1]   <= div_step(e_p[j], e_dp[j], RATIO_STEPS - 1 - j);
      e_s[j+1]   <= div_step(e_s[j], e_ds[j], RATIO_STEPS - 1 - j);
      e_dp[j+1]  <= e_dp[j];
      e_ds[j+1]  <= e_ds[j];
      e_tir[j+1] <= e_tir[j];
    end
  end

  // squares; zero denominator means a ratio of one
  logic [15:0] qp, qs;
  assign qp = (e_dp[RATIO_STEPS] == 32'd0) ? ONE_Q15 : e_p[RATIO_STEPS].quo;
  assign qs = (e_ds[RATIO_STEPS] == 32'd0) ? ONE_Q15 : e_s[RATIO_STEPS].quo;

  logic        q_v;
  logic        q_tir;
  logic [31:0] q_pp, q_ss;

  always_ff @(posedge clk) begin
    if (rst) q_v <= 1'b0;
    else q_v <= e_v[RATIO_STEPS];
    q_tir <= e_tir[RATIO_STEPS];
    q_pp  <= qp * qp;
    q_ss  <= qs * qs;
  end

  logic [32:0] sum_sq;
  logic [16:0] half_sum;
  assign sum_sq   = 33'(q_pp) + 33'(q_ss) + 33'd32768;
  assign half_sum = sum_sq[32:16];

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= q_v;
    total_internal <= q_tir;
    if (q_tir || half_sum > 17'(ONE_Q15)) reflectance <= ONE_Q15;
    else reflectance <= half_sum[15:0];
  end

  a_tir_full: assert property (@(posedge clk) disable iff (rst)
    done && total_internal |-> reflectance == ONE_Q15)
    else $error("total internal reflection without full reflectance");

  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> reflectance <= ONE_Q15)
    else $error("reflectance above one");

  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(q_v) && $past(e_v[RATIO_STEPS], 2))
    else $error("result without an item in the ratio pipe");

  a_mid_src: assert property (@(posedge clk) disable iff (rst)
    m_v |-> $past(b_v[SQRT_STEPS]))
    else $error("cross product stage valid out of order");

endmodule

/* test/fresnel_dielectric_reflectance_unit_test.sv */
// fresnel_dielectric_reflectance_unit_test: drives cosines and index settings into the
// fresnel reflectance unit and checks every result against an in-bench computation
// depends on fdr_pkg and fresnel_dielectric_reflectance_unit
`timescale 1ns / 100ps

module fresnel_dielectric_reflectance_unit_test;
  import fdr_pkg::*;

  localparam int LATENCY = 69;

  typedef struct {
    logic [15:0] refl;
    logic        tir;
  } refl_result_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic signed [15:0] cos_incident;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        done;
  logic [15:0] reflectance;
  logic        total_internal;

  logic [15:0] model_ni;
  logic [15:0] model_nt;
  refl_result_t pending_results[$];
  int failures;

  fresnel_dielectric_reflectance_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cos_incident(cos_incident),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .reflectance(reflectance), .total_internal(total_internal)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic longint unsigned amp_ratio(longint unsigned p, longint unsigned q);
    longint unsigned num;
    longint unsigned den;
    num = (p > q) ? p - q : q - p;
    den = p + q;
    if (den == 0) return 64'd32768;
    return ((num << 15) + (den >> 1)) / den;
  endfunction

  function automatic refl_result_t fresnel_predict(logic signed [15:0] cosv);
    refl_result_t r;
    int c;
    longint unsigned ni, nt, tmp, cm, si, st, ct, qp, qs, sum;
    c = cosv;
    ni = (model_ni == 0) ? 1 : model_ni;
    nt = (model_nt == 0) ? 1 : model_nt;
    if (c > 16384) c = 16384;
    if (c < -16384) c = -16384;
    // zero or negative cosine means leaving the medium
    if (c <= 0) begin
      tmp = ni;
      ni = nt;
      nt = tmp;
      cm = -c;
    end else begin
      cm = c;
    end
    si = isqrt((64'd1 << 28) - cm * cm);
    if (ni * si > nt * 16384) begin
      r.refl = 16'd32768;
      r.tir = 1'b1;
      return r;
    end
    st = (ni * si) / nt;
    ct = isqrt((64'd1 << 28) - st * st);
    qp = amp_ratio(nt * cm, ni * ct);
    qs = amp_ratio(ni * cm, nt * ct);
    sum = (qp * qp + qs * qs + (64'd1 << 15)) >> 16;
    if (sum > 32768) sum = 32768;
    r.refl = sum[15:0];
    r.tir = 1'b0;
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    refl_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result refl=%0d tir=%0b", $time, reflectance,
                 total_internal);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (reflectance !== want.refl) begin
          $display("%0t: reflectance expected %0d actual %0d", $time, want.refl, reflectance);
          failures++;
        end
        if (total_internal !== want.tir) begin
          $display("%0t: total_internal expected %0b actual %0b", $time, want.tir,
                   total_internal);
          failures++;
        end
      end
    end
  end

  // start stays high through a zero gap so transfers run back to back
  task automatic random_gap();
    int n;
    n = $urandom_range(0, 99);
    if (n < 55) n = 0;
    else if (n < 92) n = $urandom_range(1, 3);
    else n = $urandom_range(5, 40);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic send_cosine(logic signed [15:0] cosv, bit gaps);
    start <= 1'b1;
    cos_incident <= cosv;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(fresnel_predict(cosv));
    @(negedge clk);
    if (gaps) random_gap();
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_index(logic [1:0] idx, logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
    if (idx == REG_INCIDENT) model_ni = val;
    else if (idx == REG_TRANSMIT) model_nt = val;
  endtask

  task automatic set_indices(logic [15:0] ni, logic [15:0] nt);
    drain();
    write_index(REG_INCIDENT, ni);
    write_index(REG_TRANSMIT, nt);
  endtask

  logic signed [15:0] edge_cosines[] = '{16'sh7fff, 16'sh8000, 16'sd16384, -16'sd16384,
    16'sd16385, -16'sd16385, 16'sd0, 16'sd1, -16'sd1, 16'sd8192, -16'sd8192, 16'sd11585};

  task automatic test_reset_indices();
    foreach (edge_cosines[i]) send_cosine(edge_cosines[i], 1'b0);
  endtask

  task automatic test_index_extremes();
    set_indices(16'd4096, 16'd4096);
    foreach (edge_cosines[i]) send_cosine(edge_cosines[i], 1'b1);
    set_indices(16'd0, 16'hffff);
    foreach (edge_cosines[i]) send_cosine(edge_cosines[i], 1'b0);
    set_indices(16'hffff, 16'd1);
    foreach (edge_cosines[i]) send_cosine(edge_cosines[i], 1'b0);
    // unused register index must be ignored
    drain();
    write_index(2'd2, 16'd123);
    write_index(2'd3, 16'd77);
    send_cosine(16'sd5000, 1'b0);
  endtask

  task automatic test_random_stream();
    logic [15:0] ni, nt;
    for (int phase = 0; phase < 10; phase++) begin
      case (phase % 4)
        0: begin
          ni = 16'($urandom_range(3000, 8000));
          nt = 16'($urandom_range(3000, 8000));
        end
        1: begin ni = 16'($urandom); nt = 16'($urandom); end
        2: begin ni = 16'd4096; nt = 16'($urandom_range(4096, 12000)); end
        default: begin
          ni = 16'($urandom_range(0, 2));
          nt = 16'($urandom_range(65530, 65535));
        end
      endcase
      set_indices(ni, nt);
      for (int i = 0; i < 150; i++) begin
        if ($urandom_range(0, 3) == 0) send_cosine(16'($urandom), phase % 3 != 2);
        else send_cosine(16'($signed($urandom_range(0, 32768)) - 16384), phase % 3 != 2);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    cos_incident = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    model_ni = NI_RESET;
    model_nt = NT_RESET;
    failures = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_indices();
    test_index_extremes();
    test_random_stream();
    drain();
    if (failures == 0) begin
      $display("fresnel_dielectric_reflectance_unit verification clean");
    end else begin
      $display("fresnel_dielectric_reflectance_unit verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("fresnel_dielectric_reflectance_unit verification failed");
    $finish;
  end

endmodule

/* sim.f */
src/fdr_pkg.sv
src/fresnel_dielectric_reflectance_unit.sv
test/fresnel_dielectric_reflectance_unit_test.sv
